// ===== rtl/core/tcf_pkg.sv =====
// Shared types, constants and the arctangent table of the tilt filter.
package tcf_pkg;

    // Number of CORDIC micro-rotations; the table below supports up to TABLE_LEN.
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int STEP_W       = $clog2(TABLE_LEN);

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [15:0] BLEND_WEIGHT_RST = 16'd1311;
    localparam logic [31:0] GYRO_GAIN_RST    = 32'd327869;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLEND_WEIGHT = 2'd0,
        REG_GYRO_GAIN    = 2'd1
    } t_reg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              step;
        logic              pred;
        logic              wmul;
        logic              finish;
        logic [STEP_W-1:0] step_idx;
    } t_cmd;

    // atan(2^-i) in degrees, Q16, rounded to nearest.
    function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic [21:0] t;
        case (idx)
            5'd0:    t = 22'd2949120;
            5'd1:    t = 22'd1740967;
            5'd2:    t = 22'd919879;
            5'd3:    t = 22'd466945;
            5'd4:    t = 22'd234379;
            5'd5:    t = 22'd117304;
            5'd6:    t = 22'd58666;
            5'd7:    t = 22'd29335;
            5'd8:    t = 22'd14668;
            5'd9:    t = 22'd7334;
            5'd10:   t = 22'd3667;
            5'd11:   t = 22'd1833;
            5'd12:   t = 22'd917;
            5'd13:   t = 22'd458;
            5'd14:   t = 22'd229;
            5'd15:   t = 22'd115;
            5'd16:   t = 22'd57;
            5'd17:   t = 22'd29;
            5'd18:   t = 22'd14;
            5'd19:   t = 22'd7;
            5'd20:   t = 22'd4;
            5'd21:   t = 22'd2;
            5'd22:   t = 22'd1;
            default: t = 22'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/tcf_in_if.sv =====
// Input sample channel: raw accelerometer and gyroscope counts.
interface tcf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_y;

    modport source (output valid, output accel_x, output accel_z, output gyro_y, input ready);
    modport sink   (input valid, input accel_x, input accel_z, input gyro_y, output ready);
endinterface

// ===== rtl/core/tcf_out_if.sv =====
// Result channel: filtered angle, accelerometer angle and status flags.
interface tcf_out_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] angle;
    logic signed [23:0] accel_angle;
    logic               skipped;
    logic               saturated;

    modport source (output valid, output angle, output accel_angle, output skipped,
                    output saturated, input ready);
    modport sink   (input valid, input angle, input accel_angle, input skipped,
                    input saturated, output ready);
endinterface

// ===== rtl/core/tilt_complementary_filter_core.sv =====
// Top level of the tilt complementary filter: controller, datapath and channel wiring.
// A result is presented after the input transfer once the CORDIC iterations and the three
// blend stages (PRED, WMUL, FINISH) have run; FINISH waits while the output register is full.
// A new sample is taken only once the previous one has finished, as the CORDIC unit is shared.
// A finished result waits in the output register while the next sample is taken.
// Reset (i_rst_n low at a clock edge) clears the angle, the handshake state and
// loads the default blend weight and gyro gain.
module tilt_complementary_filter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tcf_in_if.sink                          i_sample,
    tcf_out_if.source                       o_result,
    input  logic                            i_cfg_we,
    input  logic [tcf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tcf_pkg::*;

    // Command bundle from the sequencer to the arithmetic.
    t_cmd cmd;
    logic in_ready;
    logic out_valid;

    // The controller steps through the CORDIC iterations and the blend stages,
    // and owns the valid flag of the output register.
    tcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // The datapath holds the configuration registers, the stored angle,
    // the CORDIC vectoring unit and the result payload.
    tcf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_accel_x     (i_sample.accel_x),
        .i_accel_z     (i_sample.accel_z),
        .i_gyro_y      (i_sample.gyro_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_angle       (o_result.angle),
        .o_accel_angle (o_result.accel_angle),
        .o_skipped     (o_result.skipped),
        .o_saturated   (o_result.saturated)
    );

    // A sample transfer happens only while the sequencer is idle.
    assign i_sample.ready = in_ready;
    assign o_result.valid = out_valid;

endmodule

// ===== rtl/core/tcf_ctrl.sv =====
// Sequencer for the tilt filter: CORDIC iterations, blend steps and output slot.
module tcf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output tcf_pkg::t_cmd o_cmd
);
    import tcf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_PRED,
        S_WMUL,
        S_FINISH
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              slot_free;
    t_cmd              cmd;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        cmd          = '0;
        cmd.step_idx = r_step;
        cmd.load     = (r_state == S_IDLE) && i_in_valid;
        cmd.step     = (r_state == S_CORDIC);
        cmd.pred     = (r_state == S_PRED);
        cmd.wmul     = (r_state == S_WMUL);
        cmd.finish   = (r_state == S_FINISH) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_in_valid) begin
                        r_state <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_PRED;
                    end
                end
                S_PRED: begin
                    r_state <= S_WMUL;
                end
                S_WMUL: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_load_starts_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> (r_state == S_CORDIC) && (r_step == '0))
        else $error("load did not start the CORDIC at step zero");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC) |-> (r_step <= LAST_STEP))
        else $error("CORDIC step counter ran past the last step");

    a_last_step_to_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC) && (r_step == LAST_STEP) |=> (r_state == S_PRED))
        else $error("CORDIC did not hand over to the blend after the last step");

    a_finish_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished result not presented");

endmodule

// ===== rtl/core/tcf_dp.sv =====
// Datapath of the tilt filter: CORDIC vectoring unit, blend arithmetic, output register.
module tcf_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcf_pkg::t_cmd                    i_cmd,
    input  logic signed [15:0]               i_accel_x,
    input  logic signed [15:0]               i_accel_z,
    input  logic signed [15:0]               i_gyro_y,
    input  logic                             i_cfg_we,
    input  logic [tcf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic signed [24:0]               o_angle,
    output logic signed [23:0]               o_accel_angle,
    output logic                             o_skipped,
    output logic                             o_saturated
);
    import tcf_pkg::*;

    localparam logic signed [24:0] ACC_MAX   = 25'sd5898240;
    localparam logic signed [36:0] ANGLE_MAX = 37'sd11796480;

    logic [15:0]        r_w;
    logic [31:0]        r_gain;
    logic signed [24:0] r_filt;

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [24:0] r_z;
    logic               r_skip;
    logic signed [48:0] r_gprod;
    logic signed [33:0] r_pred;
    logic signed [23:0] r_acc;
    logic signed [51:0] r_wprod;

    logic signed [24:0] out_angle;
    logic signed [23:0] out_acc;
    logic               out_sat;

    logic [16:0]        abs_z;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [24:0] t_ang;
    logic signed [48:0] g_rnd;
    logic signed [33:0] n_pred;
    logic signed [23:0] n_acc;
    logic signed [34:0] diff;
    logic signed [52:0] mix;
    logic signed [36:0] nv;
    logic signed [24:0] nv_clip;
    logic               nv_sat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= BLEND_WEIGHT_RST;
            r_gain <= GYRO_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLEND_WEIGHT: r_w    <= i_cfg_data[15:0];
                REG_GYRO_GAIN:    r_gain <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        abs_z  = i_accel_z[15] ? 17'(-$signed({i_accel_z[15], i_accel_z}))
                               : {1'b0, i_accel_z};
        dx     = r_y >>> i_cmd.step_idx;
        dy     = r_x >>> i_cmd.step_idx;
        t_ang  = $signed({3'b000, atan_q16(i_cmd.step_idx)});
        g_rnd  = r_gprod + 49'sd32768;
        n_pred = {{9{r_filt[24]}}, r_filt} + {g_rnd[48], g_rnd[48:16]};
        if (r_z > ACC_MAX) begin
            n_acc = ACC_MAX[23:0];
        end else if (r_z < -ACC_MAX) begin
            n_acc = 24'(-ACC_MAX);
        end else begin
            n_acc = r_z[23:0];
        end
        // (65536 - w)*pred + w*acc rewritten as 65536*pred + w*(acc - pred).
        diff = {{11{r_acc[23]}}, r_acc} - {r_pred[33], r_pred};
        mix  = {{3{r_pred[33]}}, r_pred, 16'h0000} + {r_wprod[51], r_wprod} + 53'sd32768;
        nv   = mix[52:16];
        nv_sat = 1'b1;
        if (nv > ANGLE_MAX) begin
            nv_clip = ANGLE_MAX[24:0];
        end else if (nv < -ANGLE_MAX) begin
            nv_clip = 25'(-ANGLE_MAX);
        end else begin
            nv_clip = nv[24:0];
            nv_sat  = 1'b0;
        end
        if (r_skip) begin
            out_angle = r_filt;
            out_acc   = '0;
            out_sat   = 1'b0;
        end else begin
            out_angle = nv_clip;
            out_acc   = r_acc;
            out_sat   = nv_sat;
        end
    end

    // Stored filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
        end else if (i_cmd.finish) begin
            r_filt <= out_angle;
        end
    end

    // Working registers; at most one multiply per stage.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= $signed({1'b0, abs_z, 14'h0000});
            r_y     <= $signed({{2{i_accel_x[15]}}, i_accel_x, 14'h0000});
            r_z     <= '0;
            r_skip  <= (i_accel_x == 16'sd0) && (i_accel_z == 16'sd0);
            r_gprod <= i_gyro_y * $signed({1'b0, r_gain});
        end
        if (i_cmd.step) begin
            if (!r_y[31]) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + t_ang;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - t_ang;
            end
        end
        if (i_cmd.pred) begin
            r_pred <= n_pred;
            r_acc  <= n_acc;
        end
        if (i_cmd.wmul) begin
            r_wprod <= $signed({1'b0, r_w}) * diff;
        end
        if (i_cmd.finish) begin
            o_angle       <= out_angle;
            o_accel_angle <= out_acc;
            o_skipped     <= r_skip;
            o_saturated   <= out_sat;
        end
    end

endmodule
